### rtl/core/button_average_debouncer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button average debouncer
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_AVERAGE_DEBOUNCER_UNIT_MACROS_SVH
`define BUTTON_AVERAGE_DEBOUNCER_UNIT_MACROS_SVH

// Checked only outside reset
`define BTN_AVG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included
`define BTN_AVG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/core/btn_avg_pkg.sv
// ----------------------------------------------------------------------------
// Button average debouncer package
// Types, codes and constants shared by the debouncer modules.
// ----------------------------------------------------------------------------
package btn_avg_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int NOW_BITS      = 32;
    localparam int HELD_BITS     = 32;
    localparam int AVG_BITS      = 8;
    localparam int INTERVAL_BITS = 10;
    localparam int OPCODE_BITS   = 2;
    localparam int STATE_BITS    = 3;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam int S_TDATA_BITS = 40;  // pin level, timestamp
    localparam int M_TDATA_BITS = 48;  // state, held time, average

    // Register index bit of paddr
    localparam logic REG_INVERT_LEVEL    = 1'b0;
    localparam logic REG_SAMPLE_INTERVAL = 1'b1;

    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 10'd10;

    localparam logic [AVG_BITS-1:0] AVG_FULL      = 8'd255;
    localparam logic [AVG_BITS-1:0] PRESS_LEVEL   = 8'd223;
    localparam logic [AVG_BITS-1:0] RELEASE_LEVEL = 8'd32;
    localparam logic [AVG_BITS+1:0] AVG_ROUND     = 10'd2;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_UPDATE = 2'd0,
        OP_BEGIN  = 2'd1,
        OP_STOP   = 2'd2
    } t_opcode;

    typedef enum logic [STATE_BITS-1:0] {
        ST_STOPPED  = 3'd0,
        ST_RELEASED = 3'd1,
        ST_DOWN     = 3'd2,
        ST_PRESSED  = 3'd3,
        ST_UP       = 3'd4
    } t_btn_state;

    typedef struct packed {
        logic                     invert_level;
        logic [INTERVAL_BITS-1:0] sample_interval_ms;
    } t_cfg;

    typedef struct packed {
        t_opcode             opcode;
        logic                pin_level;
        logic [NOW_BITS-1:0] now_ms;
    } t_item;

    typedef struct packed {
        t_btn_state           button_state;
        logic [HELD_BITS-1:0] held_ms;
        logic [AVG_BITS-1:0]  average_level;
    } t_result;

endpackage

### rtl/core/btn_avg_cfg.sv
// ----------------------------------------------------------------------------
// Debouncer configuration registers
// APB register file holding the level inversion and the sample interval.
// ----------------------------------------------------------------------------
module btn_avg_cfg (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [btn_avg_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [btn_avg_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [btn_avg_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                    pready,
    output btn_avg_pkg::t_cfg                       o_cfg
);

    logic                                      r_invert;
    logic                                      n_invert;
    logic [btn_avg_pkg::INTERVAL_BITS-1:0]     r_interval;
    logic [btn_avg_pkg::INTERVAL_BITS-1:0]     n_interval;
    logic                                      wr_en;
    logic                                      reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    // byte offset within the word is ignored
    assign reg_sel = paddr[btn_avg_pkg::CFG_ADDR_BITS-1];

    always_comb begin
        n_invert   = r_invert;
        n_interval = r_interval;
        if (wr_en) begin
            unique case (reg_sel)
                btn_avg_pkg::REG_INVERT_LEVEL:    n_invert = pwdata[0];
                btn_avg_pkg::REG_SAMPLE_INTERVAL:
                    n_interval = pwdata[btn_avg_pkg::INTERVAL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            btn_avg_pkg::REG_INVERT_LEVEL:
                prdata = {{(btn_avg_pkg::CFG_DATA_BITS-1){1'b0}}, r_invert};
            btn_avg_pkg::REG_SAMPLE_INTERVAL:
                prdata = {{(btn_avg_pkg::CFG_DATA_BITS-btn_avg_pkg::INTERVAL_BITS){1'b0}},
                          r_interval};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert   <= 1'b0;
            r_interval <= btn_avg_pkg::INTERVAL_RESET;
        end else begin
            r_invert   <= n_invert;
            r_interval <= n_interval;
        end
    end

    assign o_cfg.invert_level       = r_invert;
    assign o_cfg.sample_interval_ms = r_interval;

endmodule

### rtl/core/btn_avg_core.sv
// ----------------------------------------------------------------------------
// Debouncer state and update logic
// Moving average, sample timer and press state machine, one item a cycle.
// ----------------------------------------------------------------------------
module btn_avg_core #(
    parameter int TIME_BITS = btn_avg_pkg::TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  btn_avg_pkg::t_item    i_item,
    input  btn_avg_pkg::t_cfg     i_cfg,
    output btn_avg_pkg::t_result  o_result
);

    logic                                  r_running;
    logic                                  n_running;
    logic [btn_avg_pkg::AVG_BITS-1:0]      r_avg;
    logic [btn_avg_pkg::AVG_BITS-1:0]      n_avg;
    btn_avg_pkg::t_btn_state               r_state;
    btn_avg_pkg::t_btn_state               n_state;
    btn_avg_pkg::t_btn_state               sampled_state;
    btn_avg_pkg::t_btn_state               shown;
    logic [TIME_BITS-1:0]                  r_last;
    logic [TIME_BITS-1:0]                  n_last;
    logic [TIME_BITS-1:0]                  r_press;
    logic [TIME_BITS-1:0]                  n_press;
    logic [TIME_BITS-1:0]                  now_t;
    logic [TIME_BITS-1:0]                  elapsed;
    logic [TIME_BITS-1:0]                  held_t;
    logic                                  level;
    logic                                  due;
    logic [btn_avg_pkg::AVG_BITS+1:0]      mix;
    logic [btn_avg_pkg::AVG_BITS-1:0]      avg_sampled;
    logic                                  set_press;

    assign now_t   = TIME_BITS'(i_item.now_ms);
    assign level   = i_item.pin_level ^ i_cfg.invert_level;
    assign elapsed = now_t - r_last;
    assign due     = elapsed > TIME_BITS'(i_cfg.sample_interval_ms);

    // avg * 3 + level * 255 + 2, then keep a quarter
    assign mix = {2'b00, r_avg} + {1'b0, r_avg, 1'b0}
               + (level ? {2'b00, btn_avg_pkg::AVG_FULL} : '0)
               + btn_avg_pkg::AVG_ROUND;
    assign avg_sampled = mix[btn_avg_pkg::AVG_BITS+1:2];

    always_comb begin
        sampled_state = r_state;
        set_press     = 1'b0;
        unique case (r_state)
            btn_avg_pkg::ST_RELEASED: begin
                if (avg_sampled > btn_avg_pkg::PRESS_LEVEL) begin
                    sampled_state = btn_avg_pkg::ST_DOWN;
                    set_press     = 1'b1;
                end
            end
            btn_avg_pkg::ST_DOWN: sampled_state = btn_avg_pkg::ST_PRESSED;
            btn_avg_pkg::ST_PRESSED: begin
                if (avg_sampled < btn_avg_pkg::RELEASE_LEVEL)
                    sampled_state = btn_avg_pkg::ST_UP;
            end
            btn_avg_pkg::ST_UP: begin
                if (avg_sampled < btn_avg_pkg::RELEASE_LEVEL)
                    sampled_state = btn_avg_pkg::ST_RELEASED;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_running = r_running;
        n_avg     = r_avg;
        n_state   = r_state;
        n_last    = r_last;
        n_press   = r_press;
        case (i_item.opcode)
            btn_avg_pkg::OP_BEGIN: begin
                n_avg     = level ? btn_avg_pkg::AVG_FULL : '0;
                n_running = 1'b1;
            end
            btn_avg_pkg::OP_STOP: n_running = 1'b0;
            btn_avg_pkg::OP_UPDATE: begin
                if (r_running) begin
                    if (!due) begin
                        // between samples a fresh press still matures
                        if (r_state == btn_avg_pkg::ST_DOWN)
                            n_state = btn_avg_pkg::ST_PRESSED;
                    end else begin
                        n_last  = now_t;
                        n_avg   = avg_sampled;
                        n_state = sampled_state;
                        if (set_press)
                            n_press = now_t;
                    end
                end
            end
            default: ;
        endcase
    end

    assign shown  = n_running ? n_state : btn_avg_pkg::ST_STOPPED;
    assign held_t = now_t - n_press;

    assign o_result.button_state  = shown;
    assign o_result.held_ms       = (shown == btn_avg_pkg::ST_PRESSED)
                                  ? btn_avg_pkg::HELD_BITS'(held_t) : '0;
    assign o_result.average_level = n_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_avg     <= '0;
            r_state   <= btn_avg_pkg::ST_RELEASED;
            r_last    <= '0;
            r_press   <= '0;
        end else if (i_valid) begin
            r_running <= n_running;
            r_avg     <= n_avg;
            r_state   <= n_state;
            r_last    <= n_last;
            r_press   <= n_press;
        end
    end

endmodule

### rtl/core/button_average_debouncer_unit.sv
// ----------------------------------------------------------------------------
// Button average debouncer
// Moving-average button debouncer with a press state machine.
// ----------------------------------------------------------------------------
//  port group  | direction | carries
//  s_*         | in        | command items: opcode, pin level, timestamp
//  m_*         | out       | one result per item: state, held time, average
//  APB p*      | in/out    | invert_level (0x0), sample_interval_ms (0x4)
//
// One item per cycle sustained while m_tready stays high; a result is offered
// after its item is taken, through the input register and then the state update
// into the result register. The update loop in btn_avg_core sets this rate.
// Reset is synchronous; it clears both valid flags and all debounce state.
// A stalled result holds; one further item waits in the input register.
// ----------------------------------------------------------------------------
module button_average_debouncer_unit #(
    parameter int TIME_BITS = btn_avg_pkg::TIME_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [btn_avg_pkg::S_TDATA_BITS-1:0]  s_tdata,  // pin_level, now_ms
    input  logic [btn_avg_pkg::OPCODE_BITS-1:0]   s_tuser,  // opcode
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // button_state, held_ms, average_level
    output logic [btn_avg_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [btn_avg_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [btn_avg_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [btn_avg_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                  pready
);

    btn_avg_pkg::t_cfg     cfg;
    btn_avg_pkg::t_item    r_in_item;
    btn_avg_pkg::t_item    n_in_item;
    logic                  r_in_valid;
    logic                  r_out_valid;
    btn_avg_pkg::t_result  r_out;
    btn_avg_pkg::t_result  result;
    logic                  advance;
    logic                  s_take;

    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;
    assign s_take   = s_tvalid && s_tready;

    assign n_in_item.opcode    = btn_avg_pkg::t_opcode'(s_tuser);
    assign n_in_item.pin_level = s_tdata[0];
    assign n_in_item.now_ms    = s_tdata[btn_avg_pkg::NOW_BITS:1];

    btn_avg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    btn_avg_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_take)
                r_in_valid <= 1'b1;
            else if (advance)
                r_in_valid <= 1'b0;
            if (advance)
                r_out_valid <= 1'b1;
            else if (m_tready)
                r_out_valid <= 1'b0;
        end
    end

    // payload registers: input loads on take, result on advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (s_take)
            r_in_item <= n_in_item;
        if (advance)
            r_out <= result;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'b00000, r_out.average_level, r_out.held_ms, r_out.button_state};

endmodule

### rtl/core/btn_avg_chk.sv
// ----------------------------------------------------------------------------
// Debouncer port checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_average_debouncer_unit_macros.svh"

module btn_avg_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [btn_avg_pkg::M_TDATA_BITS-1:0]  m_tdata
);

    logic [btn_avg_pkg::STATE_BITS-1:0] out_state;
    logic [btn_avg_pkg::HELD_BITS-1:0]  out_held;
    logic                               out_stall;
    logic                               out_pressed;

    assign out_state   = m_tdata[2:0];
    assign out_held    = m_tdata[34:3];
    assign out_stall   = m_tvalid && !m_tready;
    assign out_pressed = (out_state == btn_avg_pkg::ST_PRESSED);

    `BTN_AVG_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(m_tdata), "stalled result moved")
    `BTN_AVG_ASSERT(a_state_code, m_tvalid |-> out_state <= btn_avg_pkg::ST_UP, "bad state code")
    `BTN_AVG_ASSERT(a_held_pressed, m_tvalid && !out_pressed |-> out_held == '0, "stray held time")
    `BTN_AVG_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !m_tvalid, "result valid after reset")

endmodule

bind button_average_debouncer_unit btn_avg_chk u_btn_avg_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/button_average_debouncer_unit_tb.sv
// ----------------------------------------------------------------------------
// Button average debouncer testbench
// Drives command items with random gaps and checks every result against an
// in-bench predictor of the average and the press state machine. The
// configuration is changed between phases, and two stress points are hit:
// a long output stall and a full drain.
// ----------------------------------------------------------------------------
module button_average_debouncer_unit_tb;
    import btn_avg_pkg::*;

    localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

    localparam logic [CFG_ADDR_BITS-1:0] ADDR_INVERT   = {REG_INVERT_LEVEL, 2'b00};
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_INTERVAL = {REG_SAMPLE_INTERVAL, 2'b00};

    localparam int IDLE_LIMIT  = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_TAIL  = 8;
    localparam int N_PHASES    = 5;
    localparam int PHASE_ITEMS = 205;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata;  // pin_level, now_ms
    logic [OPCODE_BITS-1:0]   s_tuser;  // opcode
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_BITS-1:0]  m_tdata;  // button_state, held_ms, average_level
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    button_average_debouncer_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predicts the debouncer and holds the results still owed by the block
    class debounce_scoreboard;
        logic                     cfg_invert;
        logic [INTERVAL_BITS-1:0] cfg_interval;
        logic                     running;
        logic [AVG_BITS-1:0]      level;
        t_btn_state               dstate;
        logic [NOW_BITS-1:0]      last_sample_ms;
        logic [NOW_BITS-1:0]      press_start_ms;
        t_result                  owed_q[$];
        int                       errors;
        int                       results_seen;
        int                       presses;
        int                       state_hits[8];

        function new();
            cfg_invert     = 1'b0;
            cfg_interval   = INTERVAL_RESET;
            running        = 1'b0;
            level          = '0;
            dstate         = ST_RELEASED;
            last_sample_ms = '0;
            press_start_ms = '0;
            errors         = 0;
            results_seen   = 0;
            presses        = 0;
            foreach (state_hits[i]) state_hits[i] = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_item(logic [OPCODE_BITS-1:0] op, logic pin,
                                logic [NOW_BITS-1:0] now);
            logic                b;
            logic [NOW_BITS-1:0] elapsed;
            logic [AVG_BITS+1:0] sum;
            t_result             r;
            b = pin ^ cfg_invert;
            case (op)
                OP_BEGIN: begin
                    level   = b ? AVG_FULL : '0;
                    running = 1'b1;
                end
                OP_STOP: begin
                    running = 1'b0;
                end
                OP_UPDATE: begin
                    if (running) begin
                        elapsed = now - last_sample_ms;
                        if (elapsed <= cfg_interval) begin
                            if (dstate == ST_DOWN) dstate = ST_PRESSED;
                        end else begin
                            last_sample_ms = now;
                            sum   = 3 * level + (b ? AVG_FULL : 8'd0) + AVG_ROUND;
                            level = sum[AVG_BITS+1:2];
                            if (dstate == ST_RELEASED && level > PRESS_LEVEL) begin
                                dstate         = ST_DOWN;
                                press_start_ms = now;
                                presses++;
                            end else if (dstate == ST_DOWN) begin
                                dstate = ST_PRESSED;
                            end else if (dstate == ST_PRESSED && level < RELEASE_LEVEL) begin
                                dstate = ST_UP;
                            end else if (dstate == ST_UP && level < RELEASE_LEVEL) begin
                                dstate = ST_RELEASED;
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.button_state  = running ? dstate : ST_STOPPED;
            r.held_ms       = (r.button_state == ST_PRESSED) ? now - press_start_ms : '0;
            r.average_level = level;
            owed_q.push_back(r);
        endfunction

        function void mismatch(string field, logic [31:0] want, logic [31:0] got);
            if (errors < 40)
                $display("%0t: %s expected %0h got %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(logic [M_TDATA_BITS-1:0] data);
            t_result             want;
            logic [2:0]          got_state;
            logic [HELD_BITS-1:0] got_held;
            logic [AVG_BITS-1:0] got_avg;
            got_state = data[2:0];
            got_held  = data[34:3];
            got_avg   = data[42:35];
            results_seen++;
            state_hits[got_state]++;
            if (owed_q.size() == 0) begin
                if (errors < 40)
                    $display("%0t: result %0h arrived with no item waiting", $time, data);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got_state !== want.button_state)
                mismatch("button_state", want.button_state, got_state);
            if (got_held !== want.held_ms)
                mismatch("held_ms", want.held_ms, got_held);
            if (got_avg !== want.average_level)
                mismatch("average_level", want.average_level, got_avg);
        endfunction
    endclass

    debounce_scoreboard  sb;
    logic [NOW_BITS-1:0] clock_ms;
    int                  items_sent;
    int                  idle_cycles;
    bit                  steady;
    bit                  hold_req;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; none while steady
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic [OPCODE_BITS-1:0] op, input logic pin,
                             input logic [NOW_BITS-1:0] now);
        int gap;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tuser  <= op;
        s_tdata  <= {7'd0, now, pin};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        sb.note_item(op, pin, now);
        items_sent++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [CFG_ADDR_BITS-1:0] addr,
                            output logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reprogram only once every owed result is out and the pipe has settled
    task automatic set_config(input logic invert, input logic [INTERVAL_BITS-1:0] interval);
        logic [CFG_DATA_BITS-1:0] readback;
        release_input();
        wait_drained();
        repeat (4) @(negedge i_clk);
        apb_write(ADDR_INVERT, {31'd0, invert});
        apb_write(ADDR_INTERVAL, {22'd0, interval});
        sb.cfg_invert   = invert;
        sb.cfg_interval = interval;
        apb_read(ADDR_INVERT, readback);
        if (readback !== {31'd0, invert})
            sb.mismatch("invert_level readback", {31'd0, invert}, readback);
        apb_read(ADDR_INTERVAL, readback);
        if (readback !== {22'd0, interval})
            sb.mismatch("sample_interval_ms readback", {22'd0, interval}, readback);
    endtask

    // Stopped commands, a full press and release across the timestamp wrap,
    // the elapsed-equals-interval boundary and the unused opcode
    task automatic run_directed();
        logic [NOW_BITS-1:0] t;
        send_item(OP_UPDATE, 1'b1, 32'd5);
        send_item(OP_UNUSED, 1'b1, 32'd7);
        send_item(OP_STOP, 1'b0, 32'd9);
        send_item(OP_BEGIN, 1'b1, 32'd0);
        send_item(OP_UPDATE, 1'b1, 32'd10);
        send_item(OP_UPDATE, 1'b1, 32'd11);
        send_item(OP_UPDATE, 1'b1, 32'd15);
        t = 32'hFFFF_FFF0;
        send_item(OP_UPDATE, 1'b0, t);
        repeat (8) begin
            t = t + 32'd11;
            send_item(OP_UPDATE, 1'b0, t);
        end
        send_item(OP_UNUSED, 1'b0, t);
        send_item(OP_BEGIN, 1'b0, t);
        send_item(OP_UPDATE, 1'b1, t + 32'd11);
        send_item(OP_STOP, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_UPDATE, 1'b0, 32'h0000_0000);
        send_item(OP_BEGIN, 1'b1, 32'hAAAA_5555);
        send_item(OP_UPDATE, 1'b1, 32'h5555_AAAA);
    endtask

    // One stretch of button activity: the level toggles every few samples
    // with some bounce, plus stray commands and timestamp jumps
    task automatic play_episode(input int n_items);
        logic                     target;
        logic                     pin;
        logic [OPCODE_BITS-1:0]   op;
        logic [INTERVAL_BITS-1:0] ivl;
        int                       span;
        int                       roll;
        target = $urandom_range(0, 1);
        span   = $urandom_range(6, 22);
        ivl    = sb.cfg_interval;
        clock_ms = $urandom();
        if ($urandom_range(0, 9) != 0) send_item(OP_BEGIN, target ^ sb.cfg_invert, clock_ms);
        for (int k = 0; k < n_items; k++) begin
            span--;
            if (span == 0) begin
                target = !target;
                span   = $urandom_range(6, 22);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) op = OP_STOP;
            else if (roll < 5) op = OP_UNUSED;
            else if (roll < 8) op = OP_BEGIN;
            else op = OP_UPDATE;
            roll = $urandom_range(0, 99);
            if (roll < 3) clock_ms = $urandom();
            else if (roll < 25) clock_ms = clock_ms + $urandom_range(0, ivl);
            else clock_ms = clock_ms + ivl + 1 + $urandom_range(0, ivl / 2 + 3);
            pin = target ^ sb.cfg_invert ^ ($urandom_range(0, 99) < 12);
            send_item(op, pin, clock_ms);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Output side: random stalls, and one long hold-off on request
    initial begin
        m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else begin
                int stall;
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results still owed",
                     $time, IDLE_LIMIT, sb.pending());
            $display("button_average_debouncer_unit verification failed");
            $finish;
        end
    end

    initial begin
        logic                     phase_inv[N_PHASES];
        logic [INTERVAL_BITS-1:0] phase_ivl[N_PHASES];
        int                       goal;
        phase_inv = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_ivl = '{10'd10, 10'd0, 10'd1000, 10'd37, 10'd1};
        sb          = new();
        items_sent  = 0;
        idle_cycles = 0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        clock_ms    = '0;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_UPDATE;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (int p = 0; p < N_PHASES; p++) begin
            set_config(phase_inv[p], phase_ivl[p]);
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                steady = ($urandom_range(0, 4) == 0);
                // Stall the output long enough to back the block up
                if (p == 2 && items_sent > goal - PHASE_ITEMS / 2 && !hold_req)
                    hold_req = 1'b1;
                // Pause mid-phase until every owed result has come out
                if (p == 3 && items_sent > goal - PHASE_ITEMS / 2 && steady) begin
                    release_input();
                    wait_drained();
                end
                play_episode($urandom_range(15, 60));
            end
            steady = 1'b0;
        end

        release_input();
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("covered %0d items, %0d results, %0d presses, %0d mismatches",
                 items_sent, sb.results_seen, sb.presses, sb.errors);
        $display("results by state: stopped %0d released %0d down %0d pressed %0d up %0d",
                 sb.state_hits[ST_STOPPED], sb.state_hits[ST_RELEASED],
                 sb.state_hits[ST_DOWN], sb.state_hits[ST_PRESSED], sb.state_hits[ST_UP]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("button_average_debouncer_unit verification clean");
        else
            $display("button_average_debouncer_unit verification failed");
        $finish;
    end

endmodule
